// ----- src/psrp_pkg.sv -----
// Shared types, codes and helper functions of the sample record parser.
`timescale 1ns / 1ps

package psrp_pkg;

   typedef enum logic [3:0] {
      PH_IDLE, PH_PID, PH_TID, PH_TIME, PH_CPU, PH_RESV, PH_NR, PH_FRAME,
      PH_ABI, PH_BP, PH_SP, PH_IP, PH_RAWSZ, PH_RAW, PH_DYN, PH_DRAIN
   } phase_type;

   typedef enum logic [1:0] {
      REG_SEARCHING, REG_KERNEL, REG_USER
   } region_type;

   localparam logic [3:0] KIND_PID     = 4'd0;
   localparam logic [3:0] KIND_TID     = 4'd1;
   localparam logic [3:0] KIND_TIME    = 4'd2;
   localparam logic [3:0] KIND_CPU     = 4'd3;
   localparam logic [3:0] KIND_KFRAME  = 4'd4;
   localparam logic [3:0] KIND_UFRAME  = 4'd5;
   localparam logic [3:0] KIND_BP      = 4'd6;
   localparam logic [3:0] KIND_SP      = 4'd7;
   localparam logic [3:0] KIND_IP      = 4'd8;
   localparam logic [3:0] KIND_RAWSIZE = 4'd9;
   localparam logic [3:0] KIND_DONE    = 4'd10;
   localparam logic [3:0] KIND_READ    = 4'd11;

   localparam logic        OP_PAYLOAD = 1'b0;
   localparam logic        OP_READ    = 1'b1;

   localparam logic [63:0] KERNEL_MARK = 64'hffff_ffff_ffff_ff80;
   localparam logic [63:0] USER_MARK   = 64'hffff_ffff_ffff_fe00;

   localparam logic [63:0] ABI_NONE = 64'd0;
   localparam logic [63:0] ABI_32   = 64'd1;
   localparam logic [63:0] ABI_64   = 64'd2;

   // Stack pointer offsets are taken within one 4096-byte page.
   localparam int PAGE_BITS = 12;

   localparam logic [2:0] CSR_FIELD_MASK = 3'd0;

   typedef struct packed {
      logic        operation;
      logic [7:0]  data_byte;
      logic        first;
      logic [15:0] payload_length;
      logic [12:0] read_address;
   } req_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [63:0] value;
      logic [7:0]  index;
      logic        last;
   } rsp_type;

   function automatic phase_type group_start(input logic [2:0] g);
      phase_type p;
      begin
         unique case (g)
            3'd0:    p = PH_PID;
            3'd1:    p = PH_TIME;
            3'd2:    p = PH_CPU;
            3'd3:    p = PH_NR;
            3'd4:    p = PH_ABI;
            default: p = PH_RAWSZ;
         endcase
         return p;
      end
   endfunction

   // First enabled field group at or after group g; drain when none is left.
   function automatic phase_type enter_group(input logic [2:0] g, input logic [5:0] mask);
      phase_type p;
      logic      found;
      begin
         p = PH_DRAIN;
         found = 1'b0;
         for (int i = 0; i < 6; i++) begin
            if (!found && (3'(i) >= g) && mask[i]) begin
               p = group_start(3'(i));
               found = 1'b1;
            end
         end
         return p;
      end
   endfunction

endpackage

// ----- src/psrp_stream_if.sv -----
// Valid/ready channel interface that carries one payload per transaction.
`timescale 1ns / 1ps

interface psrp_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- src/perf_sample_record_parser_core.sv -----
// A result passes through the result stage and then the result queue before it is offered.
// Throughput: one input transaction per cycle; up to two results per transaction,
// drained one per cycle through an eight-entry result queue.
// The input side stalls only while that queue holds more than four results.
// Reset is synchronous and active high; the stack store is not cleared and
// needs no clearing pass, so input is taken as soon as reset is released.
`timescale 1ns / 1ps

module perf_sample_record_parser_core #(
   parameter int STACK_DEPTH = 128,
   parameter int DUMP_LIMIT  = 4096,
   parameter int STORE_BYTES = 8192
) (
   input  logic                        clock,
   input  logic                        reset,
   psrp_stream_if.sink                 req_if,
   psrp_stream_if.source               rsp_if,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import psrp_pkg::*;

   localparam int SAW = $clog2(STORE_BYTES);
   localparam logic [16:0] STORE_W = 17'(STORE_BYTES);
   localparam logic [16:0] DUMP_W  = 17'(DUMP_LIMIT);
   localparam logic [7:0]  DEPTH_W = 8'(STACK_DEPTH);
   localparam int FIFO_DEPTH = 8;
   localparam int FPW = $clog2(FIFO_DEPTH);

   // ------------------------------------------------------------------
   // Configuration register. The field mask is read at every field group
   // boundary, so a change takes effect from the next group onward.
   // ------------------------------------------------------------------
   logic [5:0] field_mask_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_FIELD_MASK) ? {26'b0, field_mask_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_mask_ff <= 6'h3f;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_FIELD_MASK) begin
         field_mask_ff <= csr_pwdata[5:0];
      end
   end

   // ------------------------------------------------------------------
   // Parse state. One payload byte advances it by one step.
   // ------------------------------------------------------------------
   phase_type          phase_ff, phase_in;
   logic [15:0]        count_ff, count_in;
   logic [63:0]        word_ff, word_in;
   logic [2:0]         fbytes_ff, fbytes_in;
   logic [12:0]        chain_ff, chain_in;
   region_type         region_ff, region_in;
   logic [7:0]         kframes_ff, kframes_in;
   logic [7:0]         uframes_ff, uframes_in;
   logic [PAGE_BITS-1:0] spoff_ff, spoff_in;
   logic [15:0]        rawlen_ff, rawlen_in;
   logic [15:0]        rawpos_ff, rawpos_in;
   logic               wide_ff, wide_in;

   // Results of the step and the store write it makes.
   rsp_type            res0, res1;
   logic [1:0]         nres;
   logic               st_we;
   logic [SAW-1:0]     st_waddr;

   logic               req_take;
   logic               pay_take;
   req_type            rq;

   assign rq       = req_if.payload;
   assign req_take = req_if.valid && req_if.ready;
   assign pay_take = req_take && (rq.operation == OP_PAYLOAD);

   always_comb begin
      phase_type    ph;
      logic [15:0]  rem;
      logic [63:0]  w;
      logic [3:0]   fnext;
      logic [3:0]   fwidth;
      logic         active;
      logic         femit;
      rsp_type      fres;
      logic [16:0]  dest;
      logic [16:0]  copy;
      logic [16:0]  wcap;
      logic [16:0]  room;
      logic [12:0]  rem8;

      phase_in   = phase_ff;
      count_in   = count_ff;
      word_in    = word_ff;
      fbytes_in  = fbytes_ff;
      chain_in   = chain_ff;
      region_in  = region_ff;
      kframes_in = kframes_ff;
      uframes_in = uframes_ff;
      spoff_in   = spoff_ff;
      rawlen_in  = rawlen_ff;
      rawpos_in  = rawpos_ff;
      wide_in    = wide_ff;
      res0       = '0;
      res1       = '0;
      nres       = 2'd0;
      st_we      = 1'b0;
      st_waddr   = '0;
      femit      = 1'b0;
      fres       = '0;
      active     = 1'b0;
      ph         = phase_ff;
      rem        = '0;
      w          = '0;
      fnext      = '0;
      fwidth     = 4'd8;
      dest       = '0;
      copy       = '0;
      wcap       = '0;
      room       = '0;
      rem8       = '0;

      if (rq.first) begin
         // A new record restarts the parse; an open record is dropped silently.
         count_in   = rq.payload_length;
         word_in    = '0;
         fbytes_in  = '0;
         chain_in   = '0;
         region_in  = REG_SEARCHING;
         kframes_in = '0;
         uframes_in = '0;
         spoff_in   = '0;
         rawlen_in  = '0;
         rawpos_in  = '0;
         wide_in    = 1'b0;
         if (rq.payload_length == 16'd0) begin
            phase_in = PH_IDLE;
            res0 = '{kind: KIND_DONE, value: 64'd0, index: 8'd0, last: 1'b1};
            nres = 2'd1;
         end else begin
            ph = enter_group(3'd0, field_mask_ff);
            phase_in = ph;
            active = 1'b1;
         end
      end else if (phase_ff != PH_IDLE) begin
         active = 1'b1;
      end

      if (active) begin
         rem = count_in - 16'd1;
         count_in = rem;
         rem8 = rem[15:3];

         if (ph == PH_RAW) begin
            dest = 17'(spoff_in) + 17'(rawpos_in);
            if (17'(rawpos_in) < DUMP_W && dest < STORE_W) begin
               st_we = 1'b1;
               st_waddr = dest[SAW-1:0];
            end
            rawpos_in = rawpos_in + 16'd1;
            if (17'(rawpos_in) >= 17'(rawlen_in)) begin
               phase_in = PH_DYN;
            end
         end else if (ph != PH_DRAIN) begin
            w = word_in | ({56'b0, rq.data_byte} << {fbytes_in, 3'b000});
            fnext = 4'(fbytes_in) + 4'd1;
            priority case (ph)
               PH_PID, PH_TID, PH_CPU, PH_RESV: fwidth = 4'd4;
               PH_BP, PH_SP, PH_IP:             fwidth = wide_in ? 4'd8 : 4'd4;
               default:                         fwidth = 4'd8;
            endcase
            if (fnext >= fwidth) begin
               word_in = '0;
               fbytes_in = '0;
               unique case (ph)
                  PH_PID: begin
                     femit = 1'b1; fres.kind = KIND_PID; fres.value = w;
                     phase_in = PH_TID;
                  end
                  PH_TID: begin
                     femit = 1'b1; fres.kind = KIND_TID; fres.value = w;
                     phase_in = enter_group(3'd1, field_mask_ff);
                  end
                  PH_TIME: begin
                     femit = 1'b1; fres.kind = KIND_TIME; fres.value = w;
                     phase_in = enter_group(3'd2, field_mask_ff);
                  end
                  PH_CPU: begin
                     femit = 1'b1; fres.kind = KIND_CPU; fres.value = w;
                     phase_in = PH_RESV;
                  end
                  PH_RESV: phase_in = enter_group(3'd3, field_mask_ff);
                  PH_NR: begin
                     // The frame count never exceeds the whole words left.
                     chain_in = (w > {51'b0, rem8}) ? rem8 : w[12:0];
                     region_in = REG_SEARCHING;
                     phase_in = (chain_in == 13'd0) ? enter_group(3'd4, field_mask_ff)
                                                    : PH_FRAME;
                  end
                  PH_FRAME: begin
                     if (w == KERNEL_MARK) begin
                        region_in = REG_KERNEL;
                     end else if (w == USER_MARK) begin
                        region_in = REG_USER;
                     end else if (region_in == REG_KERNEL && kframes_in < DEPTH_W) begin
                        femit = 1'b1; fres.kind = KIND_KFRAME; fres.value = w;
                        fres.index = kframes_in;
                        kframes_in = kframes_in + 8'd1;
                     end else if (region_in == REG_USER && uframes_in < DEPTH_W) begin
                        femit = 1'b1; fres.kind = KIND_UFRAME; fres.value = w;
                        fres.index = uframes_in;
                        uframes_in = uframes_in + 8'd1;
                     end
                     chain_in = chain_in - 13'd1;
                     if (chain_in == 13'd0) begin
                        phase_in = enter_group(3'd4, field_mask_ff);
                     end
                  end
                  PH_ABI: begin
                     // An unknown register ABI ends decoding for this record.
                     if (w == ABI_NONE) begin
                        phase_in = enter_group(3'd5, field_mask_ff);
                     end else if (w == ABI_64) begin
                        wide_in = 1'b1; phase_in = PH_BP;
                     end else if (w == ABI_32) begin
                        wide_in = 1'b0; phase_in = PH_BP;
                     end else begin
                        phase_in = PH_DRAIN;
                     end
                  end
                  PH_BP: begin
                     femit = 1'b1; fres.kind = KIND_BP; fres.value = w;
                     phase_in = PH_SP;
                  end
                  PH_SP: begin
                     femit = 1'b1; fres.kind = KIND_SP; fres.value = w;
                     spoff_in = w[PAGE_BITS-1:0];
                     phase_in = PH_IP;
                  end
                  PH_IP: begin
                     femit = 1'b1; fres.kind = KIND_IP; fres.value = w;
                     phase_in = enter_group(3'd5, field_mask_ff);
                  end
                  PH_RAWSZ: begin
                     // A size of zero, or one the record cannot hold together
                     // with the dynamic size word, is reported as is.
                     if (w == 64'd0 || rem < 16'd8 || w > {48'b0, rem - 16'd8}) begin
                        femit = 1'b1; fres.kind = KIND_RAWSIZE; fres.value = w;
                        phase_in = PH_DRAIN;
                     end else begin
                        rawlen_in = w[15:0];
                        rawpos_in = '0;
                        phase_in = PH_RAW;
                     end
                  end
                  PH_DYN: begin
                     // Valid end = offset + min(raw size, dump limit,
                     // dynamic size, room left in the store).
                     wcap = (w > 64'(STORE_BYTES)) ? STORE_W : w[16:0];
                     copy = 17'(rawlen_in);
                     if (copy > DUMP_W) copy = DUMP_W;
                     if (copy > wcap) copy = wcap;
                     room = STORE_W - 17'(spoff_in);
                     if (copy > room) copy = room;
                     femit = 1'b1; fres.kind = KIND_RAWSIZE;
                     fres.value = 64'(copy) + 64'(spoff_in);
                     phase_in = PH_DRAIN;
                  end
                  default: ;
               endcase
            end else begin
               word_in = w;
               fbytes_in = fnext[2:0];
            end
         end

         if (femit) begin
            res0 = fres;
         end
         if (rem == 16'd0) begin
            phase_in = PH_IDLE;
            if (femit) begin
               res1 = '{kind: KIND_DONE, value: 64'(uframes_in), index: kframes_in,
                        last: 1'b1};
               nres = 2'd2;
            end else begin
               res0 = '{kind: KIND_DONE, value: 64'(uframes_in), index: kframes_in,
                        last: 1'b1};
               nres = 2'd1;
            end
         end else begin
            nres = femit ? 2'd1 : 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         count_ff   <= '0;
         word_ff    <= '0;
         fbytes_ff  <= '0;
         chain_ff   <= '0;
         region_ff  <= REG_SEARCHING;
         kframes_ff <= '0;
         uframes_ff <= '0;
         spoff_ff   <= '0;
         rawlen_ff  <= '0;
         rawpos_ff  <= '0;
         wide_ff    <= 1'b0;
      end else if (pay_take) begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         word_ff    <= word_in;
         fbytes_ff  <= fbytes_in;
         chain_ff   <= chain_in;
         region_ff  <= region_in;
         kframes_ff <= kframes_in;
         uframes_ff <= uframes_in;
         spoff_ff   <= spoff_in;
         rawlen_ff  <= rawlen_in;
         rawpos_ff  <= rawpos_in;
         wide_ff    <= wide_in;
      end
   end

   // ------------------------------------------------------------------
   // Stack store: one write port for raw stack bytes, one registered read
   // port for read transactions. A transaction is either, never both.
   // ------------------------------------------------------------------
   logic [7:0]     store_mem [STORE_BYTES];
   logic [7:0]     rdata_ff;
   logic [SAW-1:0] st_raddr;
   logic [16:0]    raddr_full;

   always_comb begin
      raddr_full = 17'(rq.read_address);
      if (raddr_full >= STORE_W) begin
         raddr_full = raddr_full - STORE_W;
      end
      st_raddr = raddr_full[SAW-1:0];
   end

   always_ff @(posedge clock) begin
      if (pay_take && st_we) begin
         store_mem[st_waddr] <= rq.data_byte;
      end
      rdata_ff <= store_mem[st_raddr];
   end

   // ------------------------------------------------------------------
   // Result stage: holds the results of the last transaction while the
   // store read completes, then hands them to the result queue.
   // ------------------------------------------------------------------
   logic [1:0] s2_n_ff;
   logic       s2_read_ff;
   rsp_type    s2_res0_ff, s2_res1_ff;
   rsp_type    push0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_n_ff    <= '0;
         s2_read_ff <= 1'b0;
      end else if (req_take && rq.operation == OP_READ) begin
         s2_n_ff    <= 2'd1;
         s2_read_ff <= 1'b1;
      end else if (pay_take) begin
         s2_n_ff    <= nres;
         s2_read_ff <= 1'b0;
      end else begin
         s2_n_ff    <= '0;
         s2_read_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      s2_res0_ff <= res0;
      s2_res1_ff <= res1;
   end

   always_comb begin
      push0 = s2_res0_ff;
      if (s2_read_ff) begin
         push0 = '{kind: KIND_READ, value: 64'(rdata_ff), index: 8'd0, last: 1'b0};
      end
   end

   // ------------------------------------------------------------------
   // Result queue. Input is taken only while at most four entries are used,
   // leaving room for the result stage and the transaction being taken.
   // ------------------------------------------------------------------
   rsp_type        fifo_ff [FIFO_DEPTH];
   logic [FPW-1:0] wptr_ff, rptr_ff;
   logic [FPW:0]   fcount_ff;
   logic           pop;

   assign pop            = rsp_if.valid && rsp_if.ready;
   assign rsp_if.valid   = (fcount_ff != '0);
   assign rsp_if.payload = fifo_ff[rptr_ff];
   assign req_if.ready   = (fcount_ff <= (FPW+1)'(FIFO_DEPTH - 4));

   always_ff @(posedge clock) begin
      if (s2_n_ff != 2'd0) begin
         fifo_ff[wptr_ff] <= push0;
      end
      if (s2_n_ff == 2'd2) begin
         fifo_ff[wptr_ff + FPW'(1)] <= s2_res1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff   <= '0;
         rptr_ff   <= '0;
         fcount_ff <= '0;
      end else begin
         wptr_ff   <= wptr_ff + FPW'(s2_n_ff);
         rptr_ff   <= rptr_ff + FPW'(pop);
         fcount_ff <= fcount_ff + (FPW+1)'(s2_n_ff) - (FPW+1)'(pop);
      end
   end

`ifndef NO_ASSERTIONS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      fcount_ff <= (FPW+1)'(FIFO_DEPTH))
      else $error("result queue overflow");

   a_read_one: assert property (@(posedge clock) disable iff (reset)
      (req_take && rq.operation == OP_READ) |=> (s2_read_ff && s2_n_ff == 2'd1))
      else $error("read transaction did not yield exactly one result");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.payload.kind == KIND_DONE) |-> rsp_if.payload.last)
      else $error("done result without last flag");
`endif

endmodule
